// ----- design/fqos_pkg.sv -----
// ----------------------------------------------------------------------------
// fqos_pkg: shared types and constants of the queue with overflow and search
// Holds the storage sizes, request and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package fqos_pkg;

  localparam int DEPTH      = 256;
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int LIM_W      = (CNT_W > 8) ? CNT_W + 1 : 9;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_LOST      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_REPORT
  } fsm_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic load;   // write push word into the cell at position count
    logic move;   // every cell takes its neighbor, tail cell takes the head
    cnt_t count;  // current number of stored words
    cnt_t tail;   // position of the last stored word
  } cell_ctl_t;

endpackage

// ----- design/fqos_cell.sv -----
// ----------------------------------------------------------------------------
// fqos_cell: one storage cell of the queue row
// Holds one word; loads a pushed word or takes its neighbor's word.
// ----------------------------------------------------------------------------
module fqos_cell (
  input  logic                clk,
  input  fqos_pkg::cell_ctl_t ctl,
  input  fqos_pkg::cnt_t      pos,
  input  fqos_pkg::word_t     push_word,
  input  fqos_pkg::word_t     nbr_word,
  input  fqos_pkg::word_t     head_word,
  output fqos_pkg::word_t     word
);

  always_ff @(posedge clk) begin
    if (ctl.load && (pos == ctl.count)) begin
      word <= push_word;
    end else if (ctl.move) begin
      // the tail closes the ring so a rotation keeps the order
      word <= (pos == ctl.tail) ? head_word : nbr_word;
    end
  end

endmodule

// ----- design/fqos_chain.sv -----
// ----------------------------------------------------------------------------
// fqos_chain: row of storage cells
// Cell zero holds the oldest word; words move one cell toward the head on a
// pop and rotate through the ring during a search.
// ----------------------------------------------------------------------------
module fqos_chain (
  input  logic                clk,
  input  fqos_pkg::cell_ctl_t ctl,
  input  fqos_pkg::word_t     push_word,
  output fqos_pkg::word_t     head_word
);

  fqos_pkg::word_t words [fqos_pkg::DEPTH];

  for (genvar i = 0; i < fqos_pkg::DEPTH; i++) begin : g_cell
    fqos_pkg::word_t nbr;

    if (i < fqos_pkg::DEPTH - 1) begin : g_mid
      assign nbr = words[i+1];
    end else begin : g_end
      assign nbr = words[0];
    end

    fqos_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (fqos_pkg::CNT_W'(i)),
      .push_word (push_word),
      .nbr_word  (nbr),
      .head_word (words[0]),
      .word      (words[i])
    );
  end

  assign head_word = words[0];

endmodule

// ----- design/fifo_queue_with_overflow_and_search.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_overflow_and_search: word queue with overflow mark and search
// Top level: request handshake, control sequencer, result register and the
// row of storage cells.
// ----------------------------------------------------------------------------
// A first-in first-out queue of 32-bit words held in a row of cells, the
// oldest word always in the head cell. Each request transaction is a push,
// pop, peek or search and yields exactly one result transaction with a
// status, the popped or peeked word and the fill level after the request.
// Push, pop and peek may follow back to back while results are taken. A search
// rotates the stored words once through the ring past the single comparator at
// the head cell, then reports once the result register is free; a search on an
// empty queue is answered directly with no data. While a search runs, no new
// request is taken. A refused push sets a sticky overflow mark that
// the next successful pop reports as lost data. Writing the capacity register
// empties the queue; capacity zero refuses every push. Write it only while no
// request is in flight.
// ----------------------------------------------------------------------------
module fifo_queue_with_overflow_and_search (
  input  logic        clk,
  input  logic        rst,
  // capacity register write
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data
  input  logic [1:0]  s_tuser,   // [1:0] op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data_out, [39:32] fill_level
  output logic [2:0]  m_tuser    // [2:0] status
);

  // state registers
  fqos_pkg::fsm_t    state;
  fqos_pkg::fsm_t    state_next;
  logic [7:0]        capacity;
  fqos_pkg::cnt_t    count;
  fqos_pkg::cnt_t    count_next;
  logic              ovf;
  logic              ovf_next;
  fqos_pkg::word_t   key;
  fqos_pkg::cnt_t    remain;
  logic              found;

  // result register
  logic              out_valid;
  fqos_pkg::status_t out_status;
  logic [31:0]       out_data;
  logic [7:0]        out_fill;

  // request decode
  fqos_pkg::op_t       op;
  fqos_pkg::word_t     req_word;
  fqos_pkg::word_t     head_word;
  fqos_pkg::cell_ctl_t ctl;
  logic                take;
  logic                out_free;
  logic                empty;
  logic                full;
  logic                load_now;
  logic                search_start;
  logic                report_now;
  fqos_pkg::status_t   res_status;
  logic [31:0]         res_data;

  assign op       = fqos_pkg::op_t'(s_tuser);
  assign req_word = fqos_pkg::word_t'(s_tdata);
  assign out_free = !out_valid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign empty    = (count == '0);
  // full at the programmed capacity or when every cell is in use
  assign full     = (fqos_pkg::LIM_W'(count) >= fqos_pkg::LIM_W'(capacity)) ||
                    (count == fqos_pkg::CNT_W'(fqos_pkg::DEPTH));

  fqos_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .push_word (req_word),
    .head_word (head_word)
  );

  // result of push, pop, peek and empty-search requests and queue bookkeeping
  always_comb begin
    res_status = fqos_pkg::ST_OK;
    res_data   = '0;
    count_next = count;
    ovf_next   = ovf;
    case (op)
      fqos_pkg::OP_PUSH: begin
        if (full) begin
          ovf_next   = 1'b1;
          res_status = fqos_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      fqos_pkg::OP_POP: begin
        if (empty) begin
          res_status = fqos_pkg::ST_NO_DATA;
        end else begin
          res_data   = 32'(head_word);
          count_next = count - 1'b1;
          if (ovf) begin
            ovf_next   = 1'b0;
            res_status = fqos_pkg::ST_LOST;
          end
        end
      end
      fqos_pkg::OP_PEEK: begin
        if (empty) begin
          res_status = fqos_pkg::ST_NO_DATA;
        end else begin
          res_data = 32'(head_word);
        end
      end
      fqos_pkg::OP_SEARCH: begin
        // a non-empty search is answered by the sequencer
        if (empty) begin
          res_status = fqos_pkg::ST_NO_DATA;
        end
      end
      default: begin
        res_status = fqos_pkg::ST_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fqos_pkg::FSM_IDLE: begin
        if (take && (op == fqos_pkg::OP_SEARCH) && !empty) begin
          state_next = fqos_pkg::FSM_SEARCH;
        end
      end
      fqos_pkg::FSM_SEARCH: begin
        // last stored word passes the comparator
        if (remain == fqos_pkg::CNT_W'(1)) begin
          state_next = fqos_pkg::FSM_REPORT;
        end
      end
      fqos_pkg::FSM_REPORT: begin
        if (out_free) begin
          state_next = fqos_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = fqos_pkg::FSM_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    ctl.load     = 1'b0;
    ctl.move     = 1'b0;
    ctl.count    = count;
    ctl.tail     = count - 1'b1;
    load_now     = 1'b0;
    search_start = 1'b0;
    report_now   = 1'b0;
    case (state)
      fqos_pkg::FSM_IDLE: begin
        s_tready     = out_free;
        ctl.load     = take && (op == fqos_pkg::OP_PUSH) && !full;
        ctl.move     = take && (op == fqos_pkg::OP_POP) && !empty;
        search_start = take && (op == fqos_pkg::OP_SEARCH) && !empty;
        load_now     = take && !search_start;
      end
      fqos_pkg::FSM_SEARCH: begin
        // rotate the stored words one place past the head comparator
        ctl.move = 1'b1;
      end
      fqos_pkg::FSM_REPORT: begin
        report_now = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fqos_pkg::FSM_IDLE;
      capacity  <= 8'd255;
      count     <= '0;
      ovf       <= 1'b0;
      remain    <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        // new capacity empties the queue
        capacity <= cfg_wr_data;
        count    <= '0;
        ovf      <= 1'b0;
      end else if (take) begin
        count <= count_next;
        ovf   <= ovf_next;
      end
      if (search_start) begin
        remain <= count;
        found  <= 1'b0;
      end else if (state == fqos_pkg::FSM_SEARCH) begin
        remain <= remain - 1'b1;
        found  <= found || (head_word == key);
      end
      if (load_now || report_now) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (search_start) begin
      key <= req_word;
    end
    if (load_now) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_fill   <= 8'(count_next);
    end else if (report_now) begin
      out_status <= found ? fqos_pkg::ST_FOUND : fqos_pkg::ST_NOT_FOUND;
      out_data   <= '0;
      out_fill   <= 8'(count);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_fill, out_data};
  assign m_tuser  = out_status;

`ifndef SYNTHESIS
  // stored words never exceed the programmed capacity or the cell count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (fqos_pkg::LIM_W'(count) <= fqos_pkg::LIM_W'(capacity)) &&
    (fqos_pkg::LIM_W'(count) <= fqos_pkg::LIM_W'(fqos_pkg::DEPTH)))
    else $error("entry count beyond capacity");

  // a running search still has stored words left to compare
  a_search_remain: assert property (@(posedge clk) disable iff (rst)
    (state == fqos_pkg::FSM_SEARCH) |-> ((remain != '0) && (remain <= count)))
    else $error("search walk count out of range");

  // a pop from a non-empty queue removes exactly one word
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (take && (op == fqos_pkg::OP_POP) && !empty && !cfg_wr_en)
      |=> (count == $past(count) - 1'b1))
    else $error("pop did not remove one word");
`endif

endmodule
